>>> rtl/hms_pkg.sv
package hms_pkg;

	localparam int ACTION_W   = 1;
	localparam int INDEX_W    = 16;
	localparam int HEIGHT_W   = 16;
	localparam int POS_W      = 24;
	localparam int OUT_W      = 24;
	localparam int ROWLEN_W   = 16;
	localparam int VCOUNT_W   = 17;
	localparam int CFG_DATA_W = 17;

	localparam logic [ROWLEN_W-1:0] ROWLEN_RESET = ROWLEN_W'(256);
	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(65536);

	typedef enum logic [ACTION_W-1:0] {
		ACT_WRITE = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	typedef enum logic [0:0] {
		CFG_ROW_LENGTH   = 1'b0,
		CFG_VERTEX_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADDR,
		ST_CHECK,
		ST_READ,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

>>> rtl/hms_if.sv
interface hms_in_if;
	import hms_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [ACTION_W-1:0]        action;
	logic [INDEX_W-1:0]         write_index;
	logic signed [HEIGHT_W-1:0] write_height;
	logic [POS_W-1:0]           pos_x;
	logic [POS_W-1:0]           pos_z;

	modport source (output valid, action, write_index, write_height, pos_x, pos_z,
		input ready);
	modport sink (input valid, action, write_index, write_height, pos_x, pos_z,
		output ready);
endinterface

interface hms_out_if;
	import hms_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] height_out;
	logic                    off_grid;

	modport source (output valid, height_out, off_grid, input ready);
	modport sink (input valid, height_out, off_grid, output ready);
endinterface

>>> rtl/heightmap_bilinear_sampler_core.sv
// channel   | direction | handshake     | payload
// in_ch     | in        | valid / ready | action, write_index, write_height, pos_x, pos_z
// out_ch    | out       | valid / ready | height_out, off_grid
// cfg       | in        | cfg_wr_en     | cfg_index, cfg_wdata
//
// a write item is written into the store at the accepting edge
// a query runs MUL, ADDR, CHECK, READ, DRAIN and DONE (out of range: CHECK to DONE)
// and waits in DONE for the result register; the four reads share the store's one port
// arst_n resets control and configuration, the store itself holds garbage until written
// a result waiting in the output register does not block the next item
module heightmap_bilinear_sampler_core #(
	parameter int MAX_VERTICES = 65536,
	parameter int FRAC_BITS    = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	hms_in_if.sink                       in_ch,
	hms_out_if.source                    out_ch,
	input  logic                         cfg_wr_en,
	input  hms_pkg::cfg_reg_t            cfg_index,
	input  logic [hms_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import hms_pkg::*;

	localparam int AW    = $clog2(MAX_VERTICES);
	localparam int IW    = POS_W - FRAC_BITS;
	localparam int PRODW = IW + ROWLEN_W;
	localparam int IDXW  = PRODW + 2;
	localparam int WW    = 2 * FRAC_BITS + 1;
	localparam int PW    = HEIGHT_W + WW + 1;
	localparam int ACCW  = PW + 2;

	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic signed [ACCW-1:0] SAT_HI = ACCW'(2 ** (OUT_W - 1) - 1);
	localparam logic signed [ACCW-1:0] SAT_LO = ~SAT_HI;

	logic [HEIGHT_W-1:0] height_mem [MAX_VERTICES];

	state_t state_q, state_d;

	logic [ROWLEN_W-1:0] row_length_q;
	logic [VCOUNT_W-1:0] vertex_count_q;

	logic [IW-1:0]        ix_q, iz_q;
	logic [FRAC_BITS-1:0] fx_q, fz_q;
	logic [PRODW-1:0]     rowprod_q, rowprod_d;
	logic [WW-1:0]        w_q [4];
	logic [WW-1:0]        w_full [4];
	logic [FRAC_BITS:0]   omx, omz;
	logic [IDXW-1:0]      idx0_q, idx2_q, idx0_d, idx2_d, limit;
	logic                 oor_q, oor_d;
	logic [1:0]           rd_cnt_q;
	logic [AW-1:0]        rd_addr;

	logic                       rd_v_s1;
	logic [1:0]                 rd_k_s1;
	logic signed [HEIGHT_W-1:0] rdata_s1;
	logic                       v_s2;
	logic signed [PW-1:0]       prod_s2;
	logic signed [ACCW-1:0]     acc_q, shifted;
	logic signed [OUT_W-1:0]    res;

	logic out_valid_q, out_oor_q;
	logic signed [OUT_W-1:0] out_height_q;

	logic accept, wr_en, rd_en, out_free, out_load, in_ready;

	assign accept   = in_ch.valid && in_ready;
	assign wr_en    = accept && (in_ch.action == ACT_WRITE)
		&& (32'(in_ch.write_index) < MAX_VERTICES);
	assign rd_en    = (state_q == ST_READ);
	assign out_free = !out_valid_q || out_ch.ready;

	// next state
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_ch.valid && in_ch.action == ACT_QUERY) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:   state_d = ST_ADDR;
			ST_ADDR:  state_d = ST_CHECK;
			ST_CHECK: state_d = oor_d ? ST_DONE : ST_READ;
			ST_READ: begin
				if (rd_cnt_q == 2'd3) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!rd_v_s1 && !v_s2) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			row_length_q   <= ROWLEN_RESET;
			vertex_count_q <= VCOUNT_RESET;
			rd_cnt_q       <= '0;
			rd_v_s1        <= 1'b0;
			v_s2           <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_ROW_LENGTH:   row_length_q <= cfg_wdata[ROWLEN_W-1:0];
					CFG_VERTEX_COUNT: vertex_count_q <= cfg_wdata[VCOUNT_W-1:0];
					default: ;
				endcase
			end
			rd_cnt_q <= rd_en ? rd_cnt_q + 2'd1 : '0;
			rd_v_s1  <= rd_en;
			v_s2     <= rd_v_s1;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// height store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			height_mem[AW'(in_ch.write_index)] <= in_ch.write_height;
		end
		if (rd_en) begin
			rdata_s1 <= height_mem[rd_addr];
		end
	end

	always_comb begin
		case (rd_cnt_q)
			2'd0:    rd_addr = idx0_q[AW-1:0];
			2'd1:    rd_addr = idx0_q[AW-1:0] + AW'(1);
			2'd2:    rd_addr = idx2_q[AW-1:0];
			2'd3:    rd_addr = idx2_q[AW-1:0] + AW'(1);
			default: rd_addr = idx0_q[AW-1:0];
		endcase
	end

	assign rowprod_d = PRODW'(iz_q) * PRODW'(row_length_q);
	assign omx       = ONE - {1'b0, fx_q};
	assign omz       = ONE - {1'b0, fz_q};
	assign w_full[0] = WW'(omx) * WW'(omz);
	assign w_full[1] = WW'(fx_q) * WW'(omz);
	assign w_full[2] = WW'(omx) * WW'(fz_q);
	assign w_full[3] = WW'(fx_q) * WW'(fz_q);

	assign idx0_d = IDXW'(rowprod_q) + IDXW'(ix_q);
	assign idx2_d = idx0_d + IDXW'(row_length_q);
	assign limit  = (IDXW'(vertex_count_q) < IDXW'(MAX_VERTICES)) ?
		IDXW'(vertex_count_q) : IDXW'(MAX_VERTICES);
	// idx3 is the largest of the four
	assign oor_d  = (limit == '0) || (idx2_q >= limit - IDXW'(1));

	assign shifted = acc_q >>> FRAC_BITS;
	assign res = (shifted > SAT_HI) ? SAT_HI[OUT_W-1:0] :
		(shifted < SAT_LO) ? SAT_LO[OUT_W-1:0] : shifted[OUT_W-1:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			ix_q <= in_ch.pos_x[POS_W-1:FRAC_BITS];
			iz_q <= in_ch.pos_z[POS_W-1:FRAC_BITS];
			fx_q <= in_ch.pos_x[FRAC_BITS-1:0];
			fz_q <= in_ch.pos_z[FRAC_BITS-1:0];
		end
		if (state_q == ST_MUL) begin
			rowprod_q <= rowprod_d;
			for (int k = 0; k < 4; k++) begin
				w_q[k] <= w_full[k];
			end
		end
		if (state_q == ST_ADDR) begin
			idx0_q <= idx0_d;
			idx2_q <= idx2_d;
		end
		if (rd_en) begin
			rd_k_s1 <= rd_cnt_q;
		end
		if (rd_v_s1) begin
			prod_s2 <= PW'(rdata_s1) * PW'($signed({1'b0, w_q[rd_k_s1]}));
		end
		if (state_q == ST_CHECK) begin
			oor_q <= oor_d;
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACCW'(prod_s2);
		end
		if (out_load) begin
			out_height_q <= oor_q ? '0 : res;
			out_oor_q    <= oor_q;
		end
	end

	assign in_ch.ready       = in_ready;
	assign out_ch.valid      = out_valid_q;
	assign out_ch.height_out = out_height_q;
	assign out_ch.off_grid   = out_oor_q;

endmodule

>>> rtl/hms_checker.sv
module hms_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [hms_pkg::ACTION_W-1:0]  in_action,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [hms_pkg::OUT_W-1:0] height_out,
	input logic                          off_grid
);
	import hms_pkg::*;

	// out of range results carry a zero height
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && off_grid |-> height_out == '0)
		else $error("out of range result with non-zero height");

	// a query keeps the block busy for at least the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_action == ACT_QUERY |=> !in_ready)
		else $error("item accepted right after a query");

	// a write item finishes in its own cycle
	a_write_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_action == ACT_WRITE |=> in_ready)
		else $error("write item stalled the input");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(height_out) && $stable(off_grid))
		else $error("stalled result changed");

endmodule

bind heightmap_bilinear_sampler_core hms_checker u_hms_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.in_action  (in_ch.action),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.height_out (out_ch.height_out),
	.off_grid   (out_ch.off_grid)
);

>>> tb/heightmap_bilinear_sampler_core_test.sv
module heightmap_bilinear_sampler_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import hms_pkg::*;

	localparam int FRAC      = 8;
	localparam int MAXV      = 65536;
	localparam longint ONE   = longint'(1) << FRAC;
	localparam int HOLD      = 20;
	localparam int PHASE_OPS = 150;
	localparam int NPHASE    = 9;
	localparam int SHOW_MAX  = 40;

	localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = 16'sh8000;
	localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = 16'sh7FFF;

	typedef struct {
		action_t                    action;
		logic [INDEX_W-1:0]         write_index;
		logic signed [HEIGHT_W-1:0] write_height;
		logic [POS_W-1:0]           pos_x;
		logic [POS_W-1:0]           pos_z;
	} grid_op_t;

	typedef struct {
		logic signed [OUT_W-1:0] height;
		logic                    oor;
	} sample_t;

	typedef longint unsigned corner_set_t [4];

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	hms_in_if  in_ch ();
	hms_out_if out_ch ();

	heightmap_bilinear_sampler_core #(
		.MAX_VERTICES(MAXV),
		.FRAC_BITS   (FRAC)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	logic [ROWLEN_W-1:0] grid_rows [NPHASE] = '{1, 65535, 0, 37, 3000, 65534, 256, 19, 2};
	logic [VCOUNT_W-1:0] grid_cnts [NPHASE] = '{65536, 65536, 1000, 0, 20000, 65536, 65536,
		513, 7};

	// predictor state
	logic [ROWLEN_W-1:0]        row_len;
	logic [VCOUNT_W-1:0]        vert_count;
	logic signed [HEIGHT_W-1:0] terrain_heights [0:MAXV-1];
	sample_t                    predicted_samples [$];

	// stimulus state
	bit       stim_loaded [0:MAXV-1];
	grid_op_t pending_ops [$];
	int       ops_made;

	grid_op_t    next_op;
	sample_t     due;
	int unsigned src_gap;
	int unsigned sink_wait;
	bit          src_burst;
	bit          sink_burst;
	int          error_count;
	int          writes_taken;
	int          queries_taken;
	int          samples_checked;
	int          samples_outside;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= SHOW_MAX)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	function automatic longint unsigned grid_limit();
		return (vert_count < MAXV) ? longint'(vert_count) : longint'(MAXV);
	endfunction

	// returns 1 when any corner lies outside the grid
	function automatic bit find_corners(input logic [POS_W-1:0] px, input logic [POS_W-1:0] pz,
		output corner_set_t c);
		longint unsigned ix;
		longint unsigned iz;
		longint unsigned lim;
		ix = px >> FRAC;
		iz = pz >> FRAC;
		lim = grid_limit();
		c[0] = iz * row_len + ix;
		c[1] = c[0] + 1;
		c[2] = (iz + 1) * row_len + ix;
		c[3] = c[2] + 1;
		return (c[0] >= lim) || (c[1] >= lim) || (c[2] >= lim) || (c[3] >= lim);
	endfunction

	function automatic sample_t predict_sample(input logic [POS_W-1:0] px,
		input logic [POS_W-1:0] pz);
		corner_set_t    c;
		sample_t        s;
		longint signed  fx;
		longint signed  fz;
		longint signed  w [4];
		longint signed  acc;
		int             k;
		s.height = '0;
		s.oor = 1'b1;
		if (find_corners(px, pz, c))
			return s;
		fx = px[FRAC-1:0];
		fz = pz[FRAC-1:0];
		w[0] = (ONE - fx) * (ONE - fz);
		w[1] = fx * (ONE - fz);
		w[2] = (ONE - fx) * fz;
		w[3] = fx * fz;
		acc = 0;
		for (k = 0; k < 4; k++)
			acc += longint'(terrain_heights[c[k][INDEX_W-1:0]]) * w[k];
		acc = acc >>> FRAC;
		if (acc > 64'sd8388607)
			acc = 64'sd8388607;
		if (acc < -64'sd8388608)
			acc = -64'sd8388608;
		s.height = acc[OUT_W-1:0];
		s.oor = 1'b0;
		return s;
	endfunction

	function automatic int unsigned pick_idle(input bit busy);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (busy || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [FRAC-1:0] rand_frac();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return FRAC'($urandom);
		endcase
	endfunction

	task automatic add_write(input logic [INDEX_W-1:0] idx, input logic signed [HEIGHT_W-1:0] h);
		grid_op_t op;
		op.action = ACT_WRITE;
		op.write_index = idx;
		op.write_height = h;
		op.pos_x = POS_W'($urandom);
		op.pos_z = POS_W'($urandom);
		pending_ops.push_back(op);
		stim_loaded[idx] = 1'b1;
		ops_made++;
	endtask

	// for a query on the grid, loads any corner not yet holding a height before it goes out
	task automatic add_query(input logic [POS_W-1:0] px, input logic [POS_W-1:0] pz);
		corner_set_t c;
		grid_op_t    op;
		int          k;
		if (!find_corners(px, pz, c))
			for (k = 0; k < 4; k++)
				if (!stim_loaded[c[k][INDEX_W-1:0]])
					add_write(c[k][INDEX_W-1:0], HEIGHT_W'($urandom));
		op.action = ACT_QUERY;
		op.write_index = INDEX_W'($urandom);
		op.write_height = HEIGHT_W'($urandom);
		op.pos_x = px;
		op.pos_z = pz;
		pending_ops.push_back(op);
		ops_made++;
	endtask

	task automatic add_random_op();
		longint unsigned lim;
		longint unsigned iz_top;
		longint unsigned ix_top;
		longint unsigned iz;
		longint unsigned ix;
		int unsigned     pick;
		lim = grid_limit();
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			add_write(INDEX_W'($urandom), HEIGHT_W'($urandom));
		end else if (pick < 30 || lim < 2 || (row_len != 0 && (lim - 2) / row_len == 0)) begin
			add_query(POS_W'($urandom), POS_W'($urandom));
		end else begin
			iz_top = (row_len == 0) ? 65535 : (lim - 2) / row_len - 1;
			if ($urandom_range(0, 9) < 6 && iz_top > 3)
				iz_top = 3;
			iz = $urandom_range(0, iz_top);
			ix_top = lim - 2 - (iz + 1) * row_len;
			case ($urandom_range(0, 9))
				0, 1: ix = ix_top;
				2: ix = ix_top + 1;
				3, 4, 5, 6: ix = $urandom_range(0, (ix_top < 31) ? ix_top : 31);
				default: ix = $urandom_range(0, ix_top);
			endcase
			add_query({ix[15:0], rand_frac()}, {iz[15:0], rand_frac()});
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_ops.size() != 0 || in_ch.valid || predicted_samples.size() != 0);
		repeat (HOLD) @(posedge clk);
	endtask

	task automatic load_grid_config(input logic [ROWLEN_W-1:0] rl,
		input logic [VCOUNT_W-1:0] vc);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_ROW_LENGTH;
		cfg_wdata <= CFG_DATA_W'(rl);
		@(posedge clk);
		row_len = rl;
		cfg_index <= CFG_VERTEX_COUNT;
		cfg_wdata <= CFG_DATA_W'(vc);
		@(posedge clk);
		vert_count = vc;
		cfg_wr_en <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			src_gap <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.action == ACT_WRITE) begin
					terrain_heights[in_ch.write_index] = in_ch.write_height;
					writes_taken++;
				end else begin
					predicted_samples.push_back(predict_sample(in_ch.pos_x, in_ch.pos_z));
					queries_taken++;
				end
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (src_gap != 0) begin
					in_ch.valid <= 1'b0;
					src_gap <= src_gap - 1;
				end else if (pending_ops.size() != 0) begin
					next_op = pending_ops.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.action <= next_op.action;
					in_ch.write_index <= next_op.write_index;
					in_ch.write_height <= next_op.write_height;
					in_ch.pos_x <= next_op.pos_x;
					in_ch.pos_z <= next_op.pos_z;
					src_gap <= pick_idle(src_burst);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
			if ($urandom_range(0, 63) == 0)
				src_burst <= !src_burst;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			sink_wait <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (predicted_samples.size() == 0) begin
					flag_error($sformatf("result with no query pending: height %0d flag %0b",
						out_ch.height_out, out_ch.off_grid));
				end else begin
					due = predicted_samples.pop_front();
					if (out_ch.height_out !== due.height)
						flag_error($sformatf("height_out %0d, predicted %0d",
							out_ch.height_out, due.height));
					if (out_ch.off_grid !== due.oor)
						flag_error($sformatf("off_grid %b, predicted %b",
							out_ch.off_grid, due.oor));
					samples_checked++;
					if (due.oor)
						samples_outside++;
				end
			end
			if (sink_wait != 0) begin
				out_ch.ready <= 1'b0;
				sink_wait <= sink_wait - 1;
			end else begin
				out_ch.ready <= 1'b1;
				sink_wait <= pick_idle(sink_burst);
			end
			if ($urandom_range(0, 63) == 0)
				sink_burst <= !sink_burst;
		end
	end

	initial begin : stimulus
		int ph;
		int phase_end;
		in_ch.valid = 1'b0;
		in_ch.action = ACT_WRITE;
		in_ch.write_index = '0;
		in_ch.write_height = '0;
		in_ch.pos_x = '0;
		in_ch.pos_z = '0;
		out_ch.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_ROW_LENGTH;
		cfg_wdata = '0;
		arst_n = 1'b0;
		row_len = ROWLEN_RESET;
		vert_count = VCOUNT_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// extreme heights around the origin, then fractions at both ends
		add_write(16'd0, HEIGHT_MIN);
		add_write(16'd1, HEIGHT_MAX);
		add_write(16'd256, HEIGHT_MAX);
		add_write(16'd257, HEIGHT_MIN);
		add_query({16'd0, 8'h00}, {16'd0, 8'h00});
		add_query({16'd0, 8'h80}, {16'd0, 8'h80});
		add_query({16'd0, 8'hFF}, {16'd0, 8'hFF});
		add_query({16'd0, 8'hFF}, {16'd0, 8'h00});
		add_write(16'hFFFF, 16'sh5A5A);
		// x at the end of a row wraps into the next one
		add_query({16'd255, 8'h40}, {16'd0, 8'hC0});
		add_query('1, '1);
		add_query({16'd65535, 8'h00}, {16'd0, 8'h00});
		add_query({16'd254, 8'hFF}, {16'd254, 8'hFF});
		add_query({16'd255, 8'h00}, {16'd254, 8'h00});
		wait_drained();

		for (ph = 0; ph < NPHASE; ph++) begin
			load_grid_config(grid_rows[ph], grid_cnts[ph]);
			phase_end = ops_made + PHASE_OPS;
			while (ops_made < phase_end)
				add_random_op();
			wait_drained();
		end

		if (predicted_samples.size() != 0)
			flag_error($sformatf("%0d samples never came out", predicted_samples.size()));
		$display("ran %0d height writes and %0d queries across %0d grid shapes",
			writes_taken, queries_taken, NPHASE + 1);
		$display("checked %0d samples, %0d of them off the grid",
			samples_checked, samples_outside);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

>>> files.f
rtl/hms_pkg.sv
rtl/hms_if.sv
rtl/heightmap_bilinear_sampler_core.sv
rtl/hms_checker.sv
tb/heightmap_bilinear_sampler_core_test.sv
